// ----- rtl/iheap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iheap_pkg
// Shared types, codes and sizes of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package iheap_pkg;

   localparam int KEY_W = 32;
   localparam int ID_W = 10;
   localparam int KIND_W = 3;
   localparam int STATUS_W = 3;

   localparam int HEAP_DEPTH_DEFAULT = 1024;
   localparam int ID_COUNT_DEFAULT = 1024;

   localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXTRACT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CHANGE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [ID_W-1:0]         id;
   } heap_entry_type;

endpackage

// ----- rtl/iheap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iheap_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module iheap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/indexed_min_heap_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap of ids with signed keys and an id-to-slot table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | kind, item_id, priority_req
//  rsp     | out       | rsp_valid/ready    | status, result_id,
//          |           |                    | result_priority, present
//
//  Steps: after acceptance the id table is looked up and the slot is read;
//  a sift-up reads and compares the parent at each level, a sift-down reads
//  the left child, then the right one, and compares (one read port per
//  memory sets this); a drop of the root reads the root, drops it and fetches
//  the last entry, and then the final write and the response follow.
//  Reset: after reset the id table is swept clean, one entry a cycle, and
//  no request is taken until the sweep is done.
//  Stalls: a finished response waits in the output register while the
//  next request is taken and worked on.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue import iheap_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT,
   parameter int ID_COUNT = ID_COUNT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [ID_W-1:0]            req_item_id,
   input  logic signed [KEY_W-1:0]    req_priority_req,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ID_W-1:0]            rsp_result_id,
   output logic signed [KEY_W-1:0]    rsp_result_priority,
   output logic                       rsp_present
);

   localparam int PW = $clog2(HEAP_DEPTH);      // heap slot index
   localparam int CW = $clog2(HEAP_DEPTH + 1);  // heap fill count
   localparam int IW = $clog2(ID_COUNT);        // id table index
   localparam int PE = PW + 1;                  // table entry: valid, slot
   localparam int EW = KEY_W + ID_W;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LK    = 4'd2;
   localparam logic [3:0] S_LKD   = 4'd3;
   localparam logic [3:0] S_OPD   = 4'd4;
   localparam logic [3:0] S_EXR   = 4'd5;
   localparam logic [3:0] S_DROP  = 4'd6;
   localparam logic [3:0] S_DLAST = 4'd7;
   localparam logic [3:0] S_SUCHK = 4'd8;
   localparam logic [3:0] S_SUCMP = 4'd9;
   localparam logic [3:0] S_SDCHK = 4'd10;
   localparam logic [3:0] S_SDL   = 4'd11;
   localparam logic [3:0] S_SDR   = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;
   localparam logic [3:0] S_RESP  = 4'd14;

   // control registers
   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;

   // request and working registers
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic signed [KEY_W-1:0] key_req_ff, key_req_in;
   logic [PW-1:0] slot_ff, slot_in;
   logic signed [KEY_W-1:0] cur_key_ff, cur_key_in;
   logic [ID_W-1:0] cur_id_ff, cur_id_in;
   heap_entry_type left_ff, left_in;

   // staged response and output register
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [ID_W-1:0] rid_ff, rid_in;
   logic signed [KEY_W-1:0] rpri_ff, rpri_in;
   logic pres_ff, pres_in;
   logic [STATUS_W-1:0] out_st_ff, out_st_in;
   logic [ID_W-1:0] out_rid_ff, out_rid_in;
   logic signed [KEY_W-1:0] out_rpri_ff, out_rpri_in;
   logic out_pres_ff, out_pres_in;

   // memory ports
   logic hw_en;
   logic [PW-1:0] hw_addr, hr_addr;
   heap_entry_type hw_data, hr_data;
   logic [EW-1:0] hr_raw;
   logic pw_en;
   logic [IW-1:0] pw_addr, pr_addr;
   logic [PE-1:0] pw_data, pr_data;

   // derived values
   logic in_range, was;
   logic [PW-1:0] parent, lk_slot;
   logic [PW:0] child_l;
   logic [PW+1:0] child_r;
   heap_entry_type sd_child;
   logic [PW:0] sd_idx;
   logic sd_right;

   iheap_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock  (clock),
      .wr_en  (hw_en),
      .wr_addr(hw_addr),
      .wr_data(hw_data),
      .rd_addr(hr_addr),
      .rd_data(hr_raw)
   );

   iheap_ram #(.WIDTH(PE), .DEPTH(ID_COUNT)) u_pos (
      .clock  (clock),
      .wr_en  (pw_en),
      .wr_addr(pw_addr),
      .wr_data(pw_data),
      .rd_addr(pr_addr),
      .rd_data(pr_data)
   );

   assign hr_data = hr_raw;

   assign in_range = 32'(id_ff) < 32'(ID_COUNT);
   assign was = in_range && pr_data[PW];
   // an out-of-date slot falls back to the root
   assign lk_slot = ((PW + 1)'(pr_data[PW-1:0]) >= (PW + 1)'(count_ff)) ? '0
                                                                       : pr_data[PW-1:0];
   assign parent = (slot_ff - 1'b1) >> 1;
   assign child_l = {slot_ff, 1'b1};
   assign child_r = (PW + 2)'(child_l) + 1'b1;

   // pick the left child unless it is strictly greater than the right one
   always_comb begin
      sd_right = (state_ff == S_SDR) && (left_ff.key > hr_data.key);
      sd_child = (state_ff == S_SDR) ? (sd_right ? hr_data : left_ff) : hr_data;
      sd_idx = sd_right ? child_r[PW:0] : child_l;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      clr_in = clr_ff;
      kind_in = kind_ff;
      id_in = id_ff;
      key_req_in = key_req_ff;
      slot_in = slot_ff;
      cur_key_in = cur_key_ff;
      cur_id_in = cur_id_ff;
      left_in = left_ff;
      st_in = st_ff;
      rid_in = rid_ff;
      rpri_in = rpri_ff;
      pres_in = pres_ff;
      out_st_in = out_st_ff;
      out_rid_in = out_rid_ff;
      out_rpri_in = out_rpri_ff;
      out_pres_in = out_pres_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      hw_en = 1'b0;
      hw_addr = slot_ff;
      hw_data = '{key: cur_key_ff, id: cur_id_ff};
      hr_addr = '0;
      pw_en = 1'b0;
      pw_addr = IW'(cur_id_ff);
      pw_data = {1'b1, slot_ff};
      pr_addr = IW'(id_ff);

      case (state_ff)
         S_CLR: begin
            // sweep the id table to absent
            pw_en = 1'b1;
            pw_addr = clr_ff;
            pw_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(ID_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               id_in = req_item_id;
               key_req_in = req_priority_req;
               state_in = S_LK;
            end
         end
         S_LK: begin
            pr_addr = IW'(id_ff);
            state_in = S_LKD;
         end
         S_LKD: begin
            st_in = ST_OK;
            rid_in = id_ff;
            rpri_in = '0;
            pres_in = was;
            state_in = S_RESP;
            case (kind_ff)
               KIND_INSERT: begin
                  if (!in_range) begin
                     st_in = ST_ABSENT;
                  end else if (was) begin
                     st_in = ST_DUP;
                  end else if (count_ff == CW'(HEAP_DEPTH)) begin
                     st_in = ST_FULL;
                  end else begin
                     slot_in = count_ff[PW-1:0];
                     count_in = count_ff + 1'b1;
                     cur_key_in = key_req_ff;
                     cur_id_in = id_ff;
                     state_in = S_SUCHK;
                  end
               end
               KIND_EXTRACT: begin
                  if (count_ff == '0) begin
                     st_in = ST_EMPTY;
                     pres_in = 1'b0;
                  end else begin
                     hr_addr = '0;
                     state_in = S_EXR;
                  end
               end
               KIND_CHANGE, KIND_REMOVE, KIND_QUERY: begin
                  if (!was) begin
                     st_in = ST_ABSENT;
                  end else begin
                     hr_addr = lk_slot;
                     slot_in = lk_slot;
                     state_in = S_OPD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_OPD: begin
            cur_id_in = hr_data.id;
            cur_key_in = key_req_ff;
            case (kind_ff)
               KIND_CHANGE: begin
                  if (hr_data.key < key_req_ff) begin
                     state_in = S_SDCHK;
                  end else if (hr_data.key > key_req_ff) begin
                     state_in = S_SUCHK;
                  end else begin
                     state_in = S_FIN;
                  end
               end
               KIND_REMOVE: begin
                  cur_key_in = KEY_MIN;
                  state_in = S_SUCHK;
               end
               default: begin
                  rpri_in = hr_data.key;
                  state_in = S_RESP;
               end
            endcase
         end
         S_EXR: begin
            rid_in = hr_data.id;
            rpri_in = hr_data.key;
            pres_in = 1'b1;
            cur_id_in = hr_data.id;
            state_in = S_DROP;
         end
         S_DROP: begin
            // drop the root's id, pull the last entry up to the root
            pw_en = 1'b1;
            pw_addr = IW'(cur_id_ff);
            pw_data = '0;
            count_in = count_ff - 1'b1;
            hr_addr = PW'(count_ff - 1'b1);
            slot_in = '0;
            state_in = (count_ff == CW'(1)) ? S_RESP : S_DLAST;
         end
         S_DLAST: begin
            cur_key_in = hr_data.key;
            cur_id_in = hr_data.id;
            state_in = S_SDCHK;
         end
         S_SUCHK: begin
            hr_addr = parent;
            if (slot_ff == '0) begin
               state_in = (kind_ff == KIND_REMOVE) ? S_DROP : S_FIN;
            end else begin
               state_in = S_SUCMP;
            end
         end
         S_SUCMP: begin
            if (hr_data.key < cur_key_ff) begin
               state_in = (kind_ff == KIND_REMOVE) ? S_DROP : S_FIN;
            end else begin
               // move the parent down into the hole
               hw_en = 1'b1;
               hw_data = hr_data;
               pw_en = 1'b1;
               pw_addr = IW'(hr_data.id);
               pw_data = {1'b1, slot_ff};
               slot_in = parent;
               state_in = S_SUCHK;
            end
         end
         S_SDCHK: begin
            hr_addr = child_l[PW-1:0];
            state_in = ((PW + 1)'(child_l) >= (PW + 1)'(count_ff)) ? S_FIN : S_SDL;
         end
         S_SDL, S_SDR: begin
            left_in = hr_data;
            hr_addr = child_r[PW-1:0];
            if ((state_ff == S_SDL) && (child_r < (PW + 2)'(count_ff))) begin
               state_in = S_SDR;
            end else if (cur_key_ff < sd_child.key) begin
               state_in = S_FIN;
            end else begin
               // move the chosen child up into the hole
               hw_en = 1'b1;
               hw_data = sd_child;
               pw_en = 1'b1;
               pw_addr = IW'(sd_child.id);
               pw_data = {1'b1, slot_ff};
               slot_in = sd_idx[PW-1:0];
               state_in = S_SDCHK;
            end
            if (state_ff == S_SDR) begin
               left_in = left_ff;
            end
         end
         S_FIN: begin
            hw_en = 1'b1;
            pw_en = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_st_in = st_ff;
               out_rid_in = rid_ff;
               out_rpri_in = rpri_ff;
               out_pres_in = pres_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         count_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      id_ff <= id_in;
      key_req_ff <= key_req_in;
      slot_ff <= slot_in;
      cur_key_ff <= cur_key_in;
      cur_id_ff <= cur_id_in;
      left_ff <= left_in;
      st_ff <= st_in;
      rid_ff <= rid_in;
      rpri_ff <= rpri_in;
      pres_ff <= pres_in;
      out_st_ff <= out_st_in;
      out_rid_ff <= out_rid_in;
      out_rpri_ff <= out_rpri_in;
      out_pres_ff <= out_pres_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = out_st_ff;
   assign rsp_result_id = out_rid_ff;
   assign rsp_result_priority = out_rpri_ff;
   assign rsp_present = out_pres_ff;

endmodule

// ----- rtl/iheap_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iheap_checker
// Port-level checks on the indexed min-heap queue responses.
// ----------------------------------------------------------------------------
module iheap_checker import iheap_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [KIND_W-1:0]       req_kind,
   input logic [ID_W-1:0]         req_item_id,
   input logic signed [KEY_W-1:0] req_priority_req,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [ID_W-1:0]         rsp_result_id,
   input logic signed [KEY_W-1:0] rsp_result_priority,
   input logic                    rsp_present
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_id))
      else $error("response dropped or changed while stalled");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> !rsp_present && rsp_result_priority == '0)
      else $error("empty response carries an item");

   a_dup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DUP |-> rsp_present)
      else $error("duplicate status on absent id");

   a_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ABSENT |-> !rsp_present && rsp_result_priority == '0)
      else $error("absent status on present id");

endmodule

bind indexed_min_heap_queue iheap_checker u_iheap_checker (.*);
